/* hw/rtl/dcfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_pkg
// Shared widths, character codes and types of the digit command frame parser.
// ----------------------------------------------------------------------------
package dcfp_pkg;

  localparam int BYTE_W   = 8;
  localparam int VALUE_W  = 14;
  localparam int DIGITS   = 4;
  localparam int ERR_LEN  = 5;
  localparam int FRAME_LEN = 6;
  localparam int IDX_W    = 3;

  localparam logic [BYTE_W-1:0] CHAR_BANG  = 8'h21;
  localparam logic [BYTE_W-1:0] CHAR_AT    = 8'h40;
  localparam logic [BYTE_W-1:0] CHAR_A     = 8'h61;
  localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'd57;

  localparam logic [IDX_W-1:0] LAST_IDX  = 3'(FRAME_LEN - 1);
  localparam logic [IDX_W-1:0] OK_LAST   = 3'(DIGITS - 1);
  localparam logic [IDX_W-1:0] ERR_LAST  = 3'(ERR_LEN - 1);

  typedef logic [BYTE_W-1:0]  byte_t;
  typedef logic [VALUE_W-1:0] value_t;

  typedef struct packed {
    logic                    load;
    logic                    ok;
    logic [DIGITS-1:0][BYTE_W-1:0] digits;
    value_t                  value;
  } reply_t;

  function automatic logic is_digit(input byte_t c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic byte_t err_char(input logic [IDX_W-1:0] pos);
    byte_t c;
    case (pos)
      3'd0:    c = 8'h45;
      3'd1:    c = 8'h72;
      3'd2:    c = 8'h72;
      3'd3:    c = 8'h6f;
      default: c = 8'h72;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/dcfp_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp channel interfaces
// Valid/ready channels for received bytes and for reply words.
// ----------------------------------------------------------------------------
interface dcfp_rx_if;
  logic                     valid;
  logic                     ready;
  logic [dcfp_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface dcfp_tx_if;
  logic                        valid;
  logic                        ready;
  logic [dcfp_pkg::BYTE_W-1:0]  tx_byte;
  logic                        last;
  logic                        frame_ok;
  logic [dcfp_pkg::VALUE_W-1:0] display_value;

  modport source (output valid, output tx_byte, output last, output frame_ok,
                  output display_value, input ready);
  modport sink   (input valid, input tx_byte, input last, input frame_ok,
                  input display_value, output ready);
endinterface

/* hw/rtl/digit_command_frame_parser_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// digit_command_frame_parser_top
// Parses "!@dddda" command frames from received bytes and replies per frame.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle while no reply run is pending. The byte that
// completes a frame starts a run of four digit-echo words (valid frame) or
// five "Error" words (invalid frame); the run leaves through the output
// register at one word per cycle while tx.ready does not hold it off, input
// is held off until the final word is in the output register, and the next
// byte is taken while that final word still waits there. display_value
// carries the held value after the frame was handled.
module digit_command_frame_parser_top (
  input  logic      clk,
  input  logic      rst,
  dcfp_rx_if.sink   rx,
  dcfp_tx_if.source tx
);
  import dcfp_pkg::*;

  reply_t reply;
  logic   busy;
  logic   accept;

  assign rx.ready = !busy;
  assign accept   = rx.valid && rx.ready;

  dcfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .reply   (reply)
  );

  dcfp_reply u_reply (
    .clk   (clk),
    .rst   (rst),
    .reply (reply),
    .busy  (busy),
    .tx    (tx)
  );

endmodule

/* hw/rtl/dcfp_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_parser
// Start pair detection, frame capture, frame check and held value.
// ----------------------------------------------------------------------------
module dcfp_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  dcfp_pkg::byte_t  rx_byte,
  output dcfp_pkg::reply_t reply
);
  import dcfp_pkg::*;

  byte_t                    prev_byte;
  logic                     capturing;
  logic [IDX_W-1:0]         capture_index;
  logic [DIGITS-1:0][BYTE_W-1:0] digit_store;
  value_t                   held_value;

  logic             restart;
  logic             cap_eff;
  logic [IDX_W-1:0] idx_eff;
  logic             complete;
  logic             frame_ok;
  logic [DIGITS-1:0][3:0] dval;
  value_t           value_next;

  assign restart  = (rx_byte == CHAR_AT) && (prev_byte == CHAR_BANG);
  assign cap_eff  = restart || capturing;
  assign idx_eff  = restart ? '0 : capture_index;
  assign complete = accept && cap_eff && (idx_eff == LAST_IDX);

  always_comb begin
    frame_ok = (rx_byte == CHAR_A);
    for (int i = 0; i < DIGITS; i++) begin
      if (!is_digit(digit_store[i])) frame_ok = 1'b0;
      dval[i] = 4'(digit_store[i] - CHAR_ZERO);
    end
    value_next = VALUE_W'(dval[0]) * VALUE_W'(1000) + VALUE_W'(dval[1]) * VALUE_W'(100)
               + VALUE_W'(dval[2]) * VALUE_W'(10) + VALUE_W'(dval[3]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte     <= CHAR_SPACE;
      capturing     <= 1'b0;
      capture_index <= '0;
      held_value    <= '0;
      reply.load    <= 1'b0;
    end else begin
      reply.load <= complete;
      if (complete) begin
        reply.ok     <= frame_ok;
        reply.digits <= digit_store;
        reply.value  <= frame_ok ? value_next : held_value;
      end
      if (accept) begin
        if (!cap_eff) begin
          prev_byte <= rx_byte;
        end else if (idx_eff == LAST_IDX) begin
          capturing     <= 1'b0;
          capture_index <= '0;
          prev_byte     <= CHAR_SPACE;
          if (frame_ok) held_value <= value_next;
        end else begin
          capturing     <= 1'b1;
          capture_index <= idx_eff + 3'd1;
          prev_byte     <= rx_byte;
        end
      end
    end
  end

  // digit bytes sit at frame positions one to four
  always_ff @(posedge clk) begin
    if (accept && cap_eff && (idx_eff != '0) && (idx_eff != LAST_IDX)) begin
      digit_store[2'(idx_eff - 3'd1)] <= rx_byte;
    end
  end

endmodule

/* hw/rtl/dcfp_reply.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcfp_reply
// Holds one reply run; a word per cycle enters the output register when free.
// ----------------------------------------------------------------------------
module dcfp_reply (
  input  logic             clk,
  input  logic             rst,
  input  dcfp_pkg::reply_t reply,
  output logic             busy,
  dcfp_tx_if.source        tx
);
  import dcfp_pkg::*;

  logic                     run_active;
  logic                     run_ok;
  logic [DIGITS-1:0][BYTE_W-1:0] run_digits;
  value_t                   run_value;
  logic [IDX_W-1:0]         pos;

  logic  out_free;
  logic  word_last;
  byte_t word_byte;

  assign busy      = run_active || reply.load;
  assign out_free  = !tx.valid || tx.ready;
  assign word_last = run_ok ? (pos == OK_LAST) : (pos == ERR_LAST);
  assign word_byte = run_ok ? run_digits[pos[1:0]] : err_char(pos);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_active <= 1'b0;
      tx.valid   <= 1'b0;
    end else begin
      if (reply.load) begin
        run_active <= 1'b1;
      end else if (run_active && out_free && word_last) begin
        run_active <= 1'b0;
      end
      if (run_active && out_free) begin
        tx.valid <= 1'b1;
      end else if (tx.ready) begin
        tx.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (reply.load) begin
      run_ok     <= reply.ok;
      run_digits <= reply.digits;
      run_value  <= reply.value;
      pos        <= '0;
    end else if (run_active && out_free) begin
      pos <= pos + 3'd1;
    end
    if (run_active && out_free) begin
      tx.tx_byte       <= word_byte;
      tx.last          <= word_last;
      tx.frame_ok      <= run_ok;
      tx.display_value <= run_value;
    end
  end

endmodule
